### src/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TCIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tcis_pkg.sv
// types and constants of the teaching cpu step block
package tcis_pkg;

  localparam int unsigned MEM_ADDR_BITS_DEF = 16;

  localparam logic [31:0] PC_RESET      = 32'h4000_0000;
  localparam logic [31:0] TERM_OUT_ADDR = 32'hFFFF_FF00;
  localparam logic [31:0] HANDLER_BIT   = 32'h0000_0004;
  localparam logic [31:0] EXIT_DISP     = 32'hFFFF_FFF8;

  localparam logic [3:0] SP_IDX = 4'd14;
  localparam logic [3:0] PC_IDX = 4'd15;
  localparam int unsigned NUM_CSR = 3;

  typedef enum logic [1:0] {
    HOP_WRITE = 2'd0,
    HOP_STEP  = 2'd1,
    HOP_READ  = 2'd2,
    HOP_REG   = 2'd3
  } host_op_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_UNK_OP = 2'd1,
    ERR_MODE   = 2'd2,
    ERR_DIV0   = 2'd3
  } err_t;

  localparam logic [2:0] CAUSE_TIMER = 3'd2;
  localparam logic [2:0] CAUSE_TERM  = 3'd3;
  localparam logic [2:0] CAUSE_SOFT  = 3'd4;

  // instruction opcodes
  localparam logic [3:0] OP_HALT  = 4'd0;
  localparam logic [3:0] OP_INT   = 4'd1;
  localparam logic [3:0] OP_CALL  = 4'd2;
  localparam logic [3:0] OP_JMP   = 4'd3;
  localparam logic [3:0] OP_SWAP  = 4'd4;
  localparam logic [3:0] OP_ARITH = 4'd5;
  localparam logic [3:0] OP_LOGIC = 4'd6;
  localparam logic [3:0] OP_SHIFT = 4'd7;
  localparam logic [3:0] OP_STORE = 4'd8;
  localparam logic [3:0] OP_LOAD  = 4'd9;

  // modes
  localparam logic [3:0] MD_CALL_DIR = 4'd0;
  localparam logic [3:0] MD_CALL_MEM = 4'd1;
  localparam logic [3:0] MD_ADD      = 4'd0;
  localparam logic [3:0] MD_SUB      = 4'd1;
  localparam logic [3:0] MD_MUL      = 4'd2;
  localparam logic [3:0] MD_DIV      = 4'd3;
  localparam logic [3:0] MD_NOT      = 4'd0;
  localparam logic [3:0] MD_AND      = 4'd1;
  localparam logic [3:0] MD_OR       = 4'd2;
  localparam logic [3:0] MD_XOR      = 4'd3;
  localparam logic [3:0] MD_SHL      = 4'd0;
  localparam logic [3:0] MD_SHR      = 4'd1;
  localparam logic [3:0] MD_ST_DIR   = 4'd0;
  localparam logic [3:0] MD_ST_PRE   = 4'd1;
  localparam logic [3:0] MD_ST_IND   = 4'd2;
  localparam logic [3:0] MD_LD_CSR   = 4'd0;
  localparam logic [3:0] MD_LD_IMM   = 4'd1;
  localparam logic [3:0] MD_LD_MEM   = 4'd2;
  localparam logic [3:0] MD_LD_POP   = 4'd3;
  localparam logic [3:0] MD_WR_CSR   = 4'd4;
  localparam logic [3:0] MD_CSR_ADD  = 4'd5;
  localparam logic [3:0] MD_CSR_MEM  = 4'd6;
  localparam logic [3:0] MD_CSR_POP  = 4'd7;

  localparam logic [1:0] JC_ALWAYS = 2'd0;
  localparam logic [1:0] JC_EQ     = 2'd1;
  localparam logic [1:0] JC_NE     = 2'd2;
  localparam logic [1:0] JC_GT     = 2'd3;

endpackage

### src/tcis_if.sv
// valid/ready channel interfaces for requests and results
interface tcis_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] address;
  logic [31:0] write_data;
  logic        timer_request;
  logic        terminal_request;

  modport source (output valid, opcode, address, write_data, timer_request,
                  terminal_request, input ready);
  modport sink   (input valid, opcode, address, write_data, timer_request,
                  terminal_request, output ready);
endinterface

interface tcis_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [31:0] program_counter;
  logic        halted;
  logic [1:0]  error_code;
  logic        char_valid;
  logic [7:0]  char_out;

  modport source (output valid, read_data, program_counter, halted, error_code,
                  char_valid, char_out, input ready);
  modport sink   (input valid, read_data, program_counter, halted, error_code,
                  char_valid, char_out, output ready);
endinterface

### src/teaching_cpu_instruction_step.sv
// multi-cycle teaching cpu core driven one transaction at a time
// Usage:
//   in_ch carries host transactions: memory word write, one instruction step,
//   memory word read, register read. out_ch returns exactly one result per
//   transaction: read data, pc after it, halt flag, error code, terminal char.
//   Memory is one byte-wide synchronous ram of 2^MEM_ADDR_BITS bytes; every
//   word access walks its four bytes one per cycle, and the register file has
//   one registered read port. A step may first enter an interrupt (push status
//   and pc, move sp, vector), then fetches, reads its operands, executes and
//   does any memory word accesses; a divide runs bit-serially, and a step
//   while halted does nothing but report.
//   Only one transaction is in flight: in_ch.ready is high only when idle.
//   After reset the core clears all of memory, one byte per cycle, with
//   in_ch.ready low; registers reset at once (pc = 0x40000000, all else 0).
//   When out_ch stalls the result holds; the core can accept and process the
//   next transaction, then waits in its final state until the old result goes.
module teaching_cpu_instruction_step
  import tcis_pkg::*;
#(
  parameter int unsigned MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tcis_in_if.sink     in_ch,
  tcis_out_if.source  out_ch
);

  localparam int unsigned MA = MEM_ADDR_BITS;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_HREG, S_HRDF, S_MRD, S_MWR,
    S_ENT0, S_ENT1, S_ENT2, S_ENT3, S_ENT4, S_FETCH, S_DEC,
    S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_EXEC, S_CALL1, S_CALL2,
    S_PCW, S_ST2, S_LDW, S_LDB, S_SWAP2, S_MUL, S_DIV, S_DIVF, S_FIN
  } state_t;

  state_t      state_r, mret_r, ent_ret_r;
  logic [MA-1:0] clr_r;
  logic [4:0]  cnt_r;

  host_op_t    hop_r;
  logic [31:0] haddr_r, hdata_r;
  logic        tmr_r, trm_r;

  logic [31:0] maddr_r, mwdata_r, word_r;
  logic        emit_r;
  logic [2:0]  cause_r;

  logic [3:0]  iop_r, mode_r, a_r, b_r, c_r;
  logic [31:0] d_r, ra_r, rb_r, rc_r, sp_r, csrb_r;

  logic [31:0] rem_r, quo_r, dvs_r, prod_r;
  logic        neg_r;

  logic [31:0] rd_r;
  err_t        err_r;
  logic        chv_r;
  logic [7:0]  chr_r;
  logic        halt_r, inh_r;

  logic [31:0] gpr_r [16];
  logic [31:0] csr_r [NUM_CSR];
  logic [31:0] gpr_q_r;
  logic [3:0]  gpr_ra;

  logic        out_valid_r;
  logic [31:0] o_rd_r, o_pc_r;
  logic        o_halt_r, o_chv_r;
  logic [1:0]  o_err_r;
  logic [7:0]  o_chr_r;

  logic [7:0]  mem [2**MA];
  logic [7:0]  mem_q_r;
  logic        mem_we;
  logic [MA-1:0] mem_wa, mem_ra, byte_addr;
  logic [7:0]  mem_wd;

  // shared datapath values
  logic [31:0] call_va, call_vb, ld_base, st_base, shl_v, shr_v;
  logic [32:0] div_sh;
  logic        jcond;

  assign byte_addr = maddr_r[MA-1:0] + MA'(cnt_r[1:0]);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_r;
    mem_wd = 8'h00;
    mem_ra = byte_addr;
    case (state_r)
      S_CLEAR: mem_we = 1'b1;
      S_MWR: begin
        mem_we = 1'b1;
        mem_wa = byte_addr;
        mem_wd = mwdata_r[{cnt_r[1:0], 3'b000} +: 8];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[mem_ra];
  end

  always_comb begin
    case (state_r)
      S_DISP:         gpr_ra = haddr_r[3:0];
      S_RD0:          gpr_ra = a_r;
      S_RD1:          gpr_ra = b_r;
      S_RD2:          gpr_ra = c_r;
      S_RD3, S_ENT0:  gpr_ra = SP_IDX;
      default:        gpr_ra = PC_IDX;
    endcase
  end

  always_comb begin
    call_va = (a_r == SP_IDX) ? sp_r - 32'd4 : ra_r;
    call_vb = (b_r == SP_IDX) ? sp_r - 32'd4 : rb_r;
    ld_base = rb_r + rc_r + d_r;
    st_base = ra_r + rb_r + d_r;
    shl_v   = (rc_r >= 32'd32) ? 32'd0 : rb_r << rc_r[4:0];
    shr_v   = (rc_r >= 32'd32) ? {32{rb_r[31]}} : 32'($signed(rb_r) >>> rc_r[4:0]);
    div_sh  = {rem_r, quo_r[31]};
    case (mode_r[1:0])
      JC_ALWAYS: jcond = 1'b1;
      JC_EQ:     jcond = (rb_r == rc_r);
      JC_NE:     jcond = (rb_r != rc_r);
      JC_GT:     jcond = ($signed(rb_r) > $signed(rc_r));
      default:   jcond = 1'b0;
    endcase
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = o_rd_r;
  assign out_ch.program_counter = o_pc_r;
  assign out_ch.halted          = o_halt_r;
  assign out_ch.error_code      = o_err_r;
  assign out_ch.char_valid      = o_chv_r;
  assign out_ch.char_out        = o_chr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      halt_r      <= 1'b0;
      inh_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) gpr_r[i] <= (i == int'(PC_IDX)) ? PC_RESET : 32'd0;
      for (int i = 0; i < NUM_CSR; i++) csr_r[i] <= '0;
    end else begin
      gpr_q_r <= gpr_r[gpr_ra];
      // the final state reloads the result register itself
      if (out_ch.valid && out_ch.ready && state_r != S_FIN) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            hop_r   <= host_op_t'(in_ch.opcode);
            haddr_r <= in_ch.address;
            hdata_r <= in_ch.write_data;
            tmr_r   <= in_ch.timer_request;
            trm_r   <= in_ch.terminal_request;
            rd_r    <= '0;
            err_r   <= ERR_NONE;
            chv_r   <= 1'b0;
            chr_r   <= '0;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          cnt_r <= '0;
          case (hop_r)
            HOP_WRITE: begin
              maddr_r  <= haddr_r;
              mwdata_r <= hdata_r;
              emit_r   <= 1'b0;
              mret_r   <= S_FIN;
              state_r  <= S_MWR;
            end
            HOP_READ: begin
              maddr_r <= haddr_r;
              mret_r  <= S_HRDF;
              state_r <= S_MRD;
            end
            HOP_REG: state_r <= S_HREG;
            default: begin
              if (halt_r) begin
                state_r <= S_FIN;
              end else if ((tmr_r || trm_r) && !inh_r) begin
                cause_r   <= trm_r ? CAUSE_TERM : CAUSE_TIMER;
                ent_ret_r <= S_FETCH;
                state_r   <= S_ENT0;
              end else begin
                state_r <= S_FETCH;
              end
            end
          endcase
        end
        S_HREG: begin
          if (haddr_r < 32'd16) rd_r <= gpr_q_r;
          else if (haddr_r < 32'd19) rd_r <= csr_r[haddr_r[1:0]];
          state_r <= S_FIN;
        end
        S_HRDF: begin
          rd_r    <= word_r;
          state_r <= S_FIN;
        end
        S_MRD: begin
          if (cnt_r != 5'd0) word_r <= {mem_q_r, word_r[31:8]};
          if (cnt_r == 5'd4) state_r <= mret_r;
          else cnt_r <= cnt_r + 5'd1;
        end
        S_MWR: begin
          if (cnt_r == 5'd0 && emit_r && maddr_r == TERM_OUT_ADDR) begin
            chv_r <= 1'b1;
            chr_r <= mwdata_r[7:0];
          end
          if (cnt_r == 5'd3) state_r <= mret_r;
          else cnt_r <= cnt_r + 5'd1;
        end
        // interrupt entry: push status, push pc, drop sp, vector
        S_ENT0: state_r <= S_ENT1;
        S_ENT1: begin
          sp_r     <= gpr_q_r;
          maddr_r  <= gpr_q_r - 32'd4;
          mwdata_r <= csr_r[0];
          emit_r   <= 1'b1;
          cnt_r    <= '0;
          mret_r   <= S_ENT2;
          state_r  <= S_MWR;
        end
        S_ENT2: begin
          maddr_r  <= sp_r - 32'd8;
          mwdata_r <= gpr_r[PC_IDX];
          cnt_r    <= '0;
          mret_r   <= S_ENT3;
          state_r  <= S_MWR;
        end
        S_ENT3: begin
          gpr_r[SP_IDX] <= sp_r - 32'd8;
          state_r       <= S_ENT4;
        end
        S_ENT4: begin
          gpr_r[PC_IDX] <= csr_r[1];
          csr_r[0]      <= csr_r[0] | HANDLER_BIT;
          csr_r[2]      <= 32'(cause_r);
          inh_r         <= 1'b1;
          state_r       <= ent_ret_r;
        end
        S_FETCH: begin
          maddr_r <= gpr_r[PC_IDX];
          cnt_r   <= '0;
          mret_r  <= S_DEC;
          state_r <= S_MRD;
        end
        S_DEC: begin
          mode_r <= word_r[3:0];
          iop_r  <= word_r[7:4];
          b_r    <= word_r[11:8];
          a_r    <= word_r[15:12];
          c_r    <= word_r[23:20];
          d_r    <= {{20{word_r[31]}}, word_r[31:24], word_r[19:16]};
          gpr_r[PC_IDX] <= gpr_r[PC_IDX] + 32'd4;
          state_r <= S_RD0;
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          ra_r    <= gpr_q_r;
          state_r <= S_RD2;
        end
        S_RD2: begin
          rb_r    <= gpr_q_r;
          csrb_r  <= (b_r < 4'(NUM_CSR)) ? csr_r[b_r[1:0]] : 32'd0;
          state_r <= S_RD3;
        end
        S_RD3: begin
          rc_r    <= gpr_q_r;
          state_r <= S_RD4;
        end
        S_RD4: begin
          sp_r    <= gpr_q_r;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          cnt_r   <= '0;
          emit_r  <= 1'b1;
          state_r <= S_FIN;
          case (iop_r)
            OP_HALT: halt_r <= 1'b1;
            OP_INT: begin
              cause_r   <= CAUSE_SOFT;
              ent_ret_r <= S_FIN;
              state_r   <= S_ENT0;
            end
            OP_CALL: begin
              maddr_r  <= sp_r - 32'd4;
              mwdata_r <= gpr_r[PC_IDX];
              mret_r   <= S_CALL1;
              state_r  <= S_MWR;
            end
            OP_JMP: begin
              if (mode_r[2]) begin
                err_r <= ERR_MODE;
              end else if (jcond) begin
                if (mode_r[3]) begin
                  maddr_r <= ra_r + d_r;
                  mret_r  <= S_PCW;
                  state_r <= S_MRD;
                end else begin
                  gpr_r[PC_IDX] <= ra_r + d_r;
                end
              end
            end
            OP_SWAP: begin
              gpr_r[b_r] <= rc_r;
              state_r    <= S_SWAP2;
            end
            OP_ARITH: begin
              case (mode_r)
                MD_ADD: gpr_r[a_r] <= rb_r + rc_r;
                MD_SUB: gpr_r[a_r] <= rb_r - rc_r;
                MD_MUL: begin
                  prod_r  <= rb_r * rc_r;
                  state_r <= S_MUL;
                end
                MD_DIV: begin
                  if (rc_r == 32'd0) begin
                    gpr_r[a_r] <= '0;
                    err_r      <= ERR_DIV0;
                  end else begin
                    rem_r   <= '0;
                    quo_r   <= rb_r[31] ? -rb_r : rb_r;
                    dvs_r   <= rc_r[31] ? -rc_r : rc_r;
                    neg_r   <= rb_r[31] ^ rc_r[31];
                    state_r <= S_DIV;
                  end
                end
                default: err_r <= ERR_MODE;
              endcase
            end
            OP_LOGIC: begin
              case (mode_r)
                MD_NOT:  gpr_r[a_r] <= ~rb_r;
                MD_AND:  gpr_r[a_r] <= rb_r & rc_r;
                MD_OR:   gpr_r[a_r] <= rb_r | rc_r;
                MD_XOR:  gpr_r[a_r] <= rb_r ^ rc_r;
                default: err_r <= ERR_MODE;
              endcase
            end
            OP_SHIFT: begin
              case (mode_r)
                MD_SHL:  gpr_r[a_r] <= shl_v;
                MD_SHR:  gpr_r[a_r] <= shr_v;
                default: err_r <= ERR_MODE;
              endcase
            end
            OP_STORE: begin
              mret_r <= S_FIN;
              case (mode_r)
                MD_ST_DIR: begin
                  maddr_r  <= st_base;
                  mwdata_r <= rc_r;
                  state_r  <= S_MWR;
                end
                MD_ST_IND: begin
                  maddr_r <= st_base;
                  mret_r  <= S_ST2;
                  state_r <= S_MRD;
                end
                MD_ST_PRE: begin
                  // the stored register sees the increment when it is the base
                  gpr_r[a_r] <= ra_r + d_r;
                  maddr_r    <= ra_r + d_r;
                  mwdata_r   <= (c_r == a_r) ? ra_r + d_r : rc_r;
                  state_r    <= S_MWR;
                end
                default: err_r <= ERR_MODE;
              endcase
            end
            OP_LOAD: begin
              mret_r <= S_LDW;
              case (mode_r)
                MD_LD_CSR: gpr_r[a_r] <= csrb_r;
                MD_LD_IMM: gpr_r[a_r] <= rb_r + d_r;
                MD_LD_MEM: begin
                  maddr_r <= ld_base;
                  if (d_r == EXIT_DISP) inh_r <= 1'b0;
                  state_r <= S_MRD;
                end
                MD_LD_POP, MD_CSR_POP: begin
                  maddr_r <= rb_r;
                  state_r <= S_MRD;
                end
                MD_WR_CSR: if (a_r < 4'(NUM_CSR)) csr_r[a_r[1:0]] <= rb_r;
                MD_CSR_ADD: if (a_r < 4'(NUM_CSR)) csr_r[a_r[1:0]] <= csrb_r + d_r;
                MD_CSR_MEM: begin
                  maddr_r <= ld_base;
                  state_r <= S_MRD;
                end
                default: err_r <= ERR_MODE;
              endcase
            end
            default: err_r <= ERR_UNK_OP;
          endcase
        end
        S_CALL1: begin
          gpr_r[SP_IDX] <= sp_r - 32'd4;
          state_r       <= S_CALL2;
        end
        S_CALL2: begin
          state_r <= S_FIN;
          case (mode_r)
            MD_CALL_DIR: gpr_r[PC_IDX] <= call_va + call_vb + d_r;
            MD_CALL_MEM: begin
              maddr_r <= call_va + call_vb + d_r;
              cnt_r   <= '0;
              mret_r  <= S_PCW;
              state_r <= S_MRD;
            end
            default: err_r <= ERR_MODE;
          endcase
        end
        S_PCW: begin
          gpr_r[PC_IDX] <= word_r;
          state_r       <= S_FIN;
        end
        S_ST2: begin
          maddr_r  <= word_r;
          mwdata_r <= rc_r;
          cnt_r    <= '0;
          mret_r   <= S_FIN;
          state_r  <= S_MWR;
        end
        S_LDW: begin
          state_r <= S_FIN;
          case (mode_r)
            MD_LD_MEM: gpr_r[a_r] <= word_r;
            MD_LD_POP: begin
              gpr_r[a_r] <= word_r;
              state_r    <= S_LDB;
            end
            MD_CSR_MEM: if (a_r < 4'(NUM_CSR)) csr_r[a_r[1:0]] <= word_r;
            MD_CSR_POP: begin
              if (a_r < 4'(NUM_CSR)) csr_r[a_r[1:0]] <= word_r;
              state_r <= S_LDB;
            end
            default: ;
          endcase
        end
        S_LDB: begin
          // post-increment sees the loaded value when base and target coincide
          gpr_r[b_r] <= ((mode_r == MD_LD_POP && a_r == b_r) ? word_r : rb_r) + d_r;
          state_r    <= S_FIN;
        end
        S_SWAP2: begin
          gpr_r[c_r] <= rb_r;
          state_r    <= S_FIN;
        end
        S_MUL: begin
          gpr_r[a_r] <= prod_r;
          state_r    <= S_FIN;
        end
        S_DIV: begin
          // restoring divide on magnitudes, one quotient bit per cycle
          if (div_sh >= {1'b0, dvs_r}) begin
            rem_r <= 32'(div_sh - {1'b0, dvs_r});
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= div_sh[31:0];
            quo_r <= {quo_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (&cnt_r) state_r <= S_DIVF;
        end
        S_DIVF: begin
          gpr_r[a_r] <= neg_r ? -quo_r : quo_r;
          state_r    <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_rd_r      <= rd_r;
            o_pc_r      <= gpr_r[PC_IDX];
            o_halt_r    <= halt_r;
            o_err_r     <= err_r;
            o_chv_r     <= chv_r;
            o_chr_r     <= chr_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### src/tcis_checker.sv
// port-level checker for the teaching cpu step block, bound to the top level
`include "assert_macros.svh"

module tcis_checker
  import tcis_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic [31:0] out_program_counter,
  input logic [1:0]  out_error_code,
  input logic        out_char_valid,
  input logic [7:0]  out_char_out
);

  `TCIS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_data) && $stable(out_program_counter), "stalled result changed")

  `TCIS_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction taken while busy")

  `TCIS_ASSERT_IMP(a_char_zero, out_valid && !out_char_valid, out_char_out == 8'h00, "char byte set without char valid")

endmodule

bind teaching_cpu_instruction_step tcis_checker u_tcis_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_read_data       (out_ch.read_data),
  .out_program_counter (out_ch.program_counter),
  .out_error_code      (out_ch.error_code),
  .out_char_valid      (out_ch.char_valid),
  .out_char_out        (out_ch.char_out)
);

### tb/tb_top.sv
// testbench of teaching_cpu_instruction_step: directed table, random programs, step predictor
`timescale 1ns / 1ps

module tb_top;
  import tcis_pkg::*;

  localparam int unsigned MEM_BYTES = 1 << MEM_ADDR_BITS_DEF;
  localparam logic [31:0] MEM_MASK = MEM_BYTES - 1;
  localparam int unsigned IDLE_PCT = 38;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 250;

  typedef struct {
    logic [31:0] rd;
    logic [31:0] pc;
    logic        halted;
    err_t        err;
    logic        cv;
    logic [7:0]  ch;
  } result_t;

  typedef struct {
    host_op_t    op;
    logic [31:0] addr;
    logic [31:0] data;
    logic        tmr;
    logic        trm;
    bit          typed;
    logic [31:0] exp_rd;
    err_t        exp_err;
  } row_t;

  logic clk;
  logic rst_n;
  tcis_in_if in_ch ();
  tcis_out_if out_ch ();

  teaching_cpu_instruction_step i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow cpu state
  logic [31:0] gpr [16];
  logic [31:0] csr [NUM_CSR];
  logic [7:0]  mem [MEM_BYTES];
  bit          in_isr;
  bit          cpu_halted;
  bit          chr_seen;
  logic [7:0]  chr_byte;

  result_t expected_results [$];
  int unsigned mismatch_count = 0;
  bit quiet = 0;
  bit hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] mem_word(logic [31:0] a);
    logic [31:0] v;
    v = '0;
    for (int i = 3; i >= 0; i--) v = {v[23:0], mem[(a + i) & MEM_MASK]};
    return v;
  endfunction

  function automatic void mem_store(logic [31:0] a, logic [31:0] v, bit to_term);
    for (int i = 0; i < 4; i++) mem[(a + i) & MEM_MASK] = v[8*i +: 8];
    if (to_term && a == TERM_OUT_ADDR) begin
      chr_seen = 1;
      chr_byte = v[7:0];
    end
  endfunction

  function automatic logic [31:0] csr_get(logic [31:0] i);
    return i < NUM_CSR ? csr[i] : '0;
  endfunction

  function automatic void csr_set(logic [31:0] i, logic [31:0] v);
    if (i < NUM_CSR) csr[i] = v;
  endfunction

  function automatic void take_interrupt(logic [2:0] cause);
    logic [31:0] sp;
    sp = gpr[SP_IDX];
    in_isr = 1;
    mem_store(sp - 4, csr[0], 1);
    mem_store(sp - 8, gpr[PC_IDX], 1);
    gpr[SP_IDX] = sp - 8;
    csr[0] = csr[0] | HANDLER_BIT;
    csr[2] = {29'd0, cause};
    gpr[PC_IDX] = csr[1];
  endfunction

  function automatic err_t run_instruction();
    logic [31:0] w, d, t, x, y;
    logic [3:0] op, md, a, b, c;
    bit cond;
    w = mem_word(gpr[PC_IDX]);
    op = w[7:4];
    md = w[3:0];
    a = w[15:12];
    b = w[11:8];
    c = w[23:20];
    d = {{20{w[31]}}, w[31:24], w[19:16]};
    gpr[PC_IDX] = gpr[PC_IDX] + 4;
    case (op)
      OP_HALT: begin
        cpu_halted = 1;
        return ERR_NONE;
      end
      OP_INT: begin
        take_interrupt(CAUSE_SOFT);
        return ERR_NONE;
      end
      OP_CALL: begin
        mem_store(gpr[SP_IDX] - 4, gpr[PC_IDX], 1);
        gpr[SP_IDX] = gpr[SP_IDX] - 4;
        if (md == MD_CALL_DIR) gpr[PC_IDX] = gpr[a] + gpr[b] + d;
        else if (md == MD_CALL_MEM) gpr[PC_IDX] = mem_word(gpr[a] + gpr[b] + d);
        else return ERR_MODE;
        return ERR_NONE;
      end
      OP_JMP: begin
        // modes 0-3 direct, 8-11 through memory
        if (md[2]) return ERR_MODE;
        case (md[1:0])
          JC_ALWAYS: cond = 1;
          JC_EQ:     cond = gpr[b] == gpr[c];
          JC_NE:     cond = gpr[b] != gpr[c];
          default:   cond = $signed(gpr[b]) > $signed(gpr[c]);
        endcase
        if (cond) gpr[PC_IDX] = md[3] ? mem_word(gpr[a] + d) : gpr[a] + d;
        return ERR_NONE;
      end
      OP_SWAP: begin
        t = gpr[b];
        gpr[b] = gpr[c];
        gpr[c] = t;
        return ERR_NONE;
      end
      OP_ARITH: begin
        x = gpr[b];
        y = gpr[c];
        case (md)
          MD_ADD: gpr[a] = x + y;
          MD_SUB: gpr[a] = x - y;
          MD_MUL: gpr[a] = x * y;
          MD_DIV: begin
            if (y == 0) begin
              gpr[a] = '0;
              return ERR_DIV0;
            end
            if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) gpr[a] = 32'h8000_0000;
            else gpr[a] = $signed(x) / $signed(y);
          end
          default: return ERR_MODE;
        endcase
        return ERR_NONE;
      end
      OP_LOGIC: begin
        case (md)
          MD_NOT: gpr[a] = ~gpr[b];
          MD_AND: gpr[a] = gpr[b] & gpr[c];
          MD_OR:  gpr[a] = gpr[b] | gpr[c];
          MD_XOR: gpr[a] = gpr[b] ^ gpr[c];
          default: return ERR_MODE;
        endcase
        return ERR_NONE;
      end
      OP_SHIFT: begin
        x = gpr[b];
        y = gpr[c];
        if (md == MD_SHL) gpr[a] = y >= 32 ? '0 : x << y[4:0];
        else if (md == MD_SHR) gpr[a] = $signed(x) >>> (y >= 32 ? 31 : y[4:0]);
        else return ERR_MODE;
        return ERR_NONE;
      end
      OP_STORE: begin
        if (md == MD_ST_DIR) mem_store(gpr[a] + gpr[b] + d, gpr[c], 1);
        else if (md == MD_ST_IND) mem_store(mem_word(gpr[a] + gpr[b] + d), gpr[c], 1);
        else if (md == MD_ST_PRE) begin
          gpr[a] = gpr[a] + d;
          mem_store(gpr[a], gpr[c], 1);
        end else return ERR_MODE;
        return ERR_NONE;
      end
      OP_LOAD: begin
        case (md)
          MD_LD_CSR: gpr[a] = csr_get(b);
          MD_LD_IMM: gpr[a] = gpr[b] + d;
          MD_LD_MEM: begin
            gpr[a] = mem_word(gpr[b] + gpr[c] + d);
            if (d == EXIT_DISP) in_isr = 0;
          end
          MD_LD_POP: begin
            t = gpr[b];
            gpr[a] = mem_word(t);
            gpr[b] = gpr[b] + d;
          end
          MD_WR_CSR:  csr_set(a, gpr[b]);
          MD_CSR_ADD: csr_set(a, csr_get(b) + d);
          MD_CSR_MEM: csr_set(a, mem_word(gpr[b] + gpr[c] + d));
          MD_CSR_POP: begin
            t = gpr[b];
            csr_set(a, mem_word(t));
            gpr[b] = gpr[b] + d;
          end
          default: return ERR_MODE;
        endcase
        return ERR_NONE;
      end
      default: return ERR_UNK_OP;
    endcase
  endfunction

  function automatic result_t cpu_transaction(host_op_t op, logic [31:0] addr,
                                              logic [31:0] data, logic tmr, logic trm);
    result_t r;
    r.rd = '0;
    r.err = ERR_NONE;
    chr_seen = 0;
    chr_byte = '0;
    case (op)
      HOP_WRITE: mem_store(addr, data, 0);
      HOP_READ:  r.rd = mem_word(addr);
      HOP_REG: begin
        if (addr < 16) r.rd = gpr[addr[3:0]];
        else if (addr < 16 + NUM_CSR) r.rd = csr[addr - 16];
      end
      default: begin
        if (!cpu_halted) begin
          if ((tmr || trm) && !in_isr) take_interrupt(trm ? CAUSE_TERM : CAUSE_TIMER);
          r.err = run_instruction();
        end
      end
    endcase
    r.pc = gpr[PC_IDX];
    r.halted = cpu_halted;
    r.cv = chr_seen;
    r.ch = chr_byte;
    return r;
  endfunction

  function automatic logic [31:0] encode(logic [3:0] op, logic [3:0] md, logic [3:0] a,
                                         logic [3:0] b, logic [3:0] c, logic [11:0] d);
    return {d[11:4], c, d[3:0], a, b, op, md};
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch %s: got %h, expected %h at %0t", field, got, want, $realtime);
  endtask

  // drive one transaction and record what it should return
  task automatic send(host_op_t op, logic [31:0] addr, logic [31:0] data,
                      logic tmr, logic trm, bit typed = 0,
                      logic [31:0] exp_rd = '0, err_t exp_err = ERR_NONE);
    result_t r;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.address <= addr;
    in_ch.write_data <= data;
    in_ch.timer_request <= tmr;
    in_ch.terminal_request <= trm;
    do @(posedge clk); while (!in_ch.ready);
    r = cpu_transaction(op, addr, data, tmr, trm);
    if (typed) begin
      r.rd = exp_rd;
      r.err = exp_err;
    end
    expected_results.push_back(r);
  endtask

  // place an instruction at the current pc, then execute it
  task automatic step_with(logic [31:0] insn, logic tmr, logic trm, bit typed = 0,
                           err_t exp_err = ERR_NONE);
    send(HOP_WRITE, gpr[PC_IDX], insn, 0, 0);
    send(HOP_STEP, $urandom, $urandom, tmr, trm, typed, '0, exp_err);
  endtask

  function automatic logic [31:0] random_insn();
    logic [3:0] op, md;
    op = $urandom_range(99) < 92 ? 4'($urandom_range(9, 1)) : 4'($urandom_range(15, 10));
    if ($urandom_range(9) == 0) md = 4'($urandom);
    else if (op == OP_LOAD) md = 4'($urandom_range(7));
    else if (op == OP_JMP) md = {1'($urandom_range(1)), 1'b0, 2'($urandom)};
    else md = 4'($urandom_range(3));
    return encode(op, md, 4'($urandom), 4'($urandom), 4'($urandom), 12'($urandom));
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", out_ch.program_counter, '0);
        end else begin
          e = expected_results.pop_front();
          if (out_ch.read_data !== e.rd) report_mismatch("read_data", out_ch.read_data, e.rd);
          if (out_ch.program_counter !== e.pc)
            report_mismatch("program_counter", out_ch.program_counter, e.pc);
          if (out_ch.halted !== e.halted) report_mismatch("halted", out_ch.halted, e.halted);
          if (out_ch.error_code !== e.err) report_mismatch("error_code", out_ch.error_code, e.err);
          if (out_ch.char_valid !== e.cv) report_mismatch("char_valid", out_ch.char_valid, e.cv);
          if (out_ch.char_out !== e.ch) report_mismatch("char_out", out_ch.char_out, e.ch);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= quiet || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("FAIL teaching_cpu_instruction_step");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    int unsigned pick;
    for (int i = 0; i < 16; i++) gpr[i] = '0;
    gpr[PC_IDX] = PC_RESET;
    for (int i = 0; i < NUM_CSR; i++) csr[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) mem[i] = '0;
    in_isr = 0;
    cpu_halted = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.opcode = HOP_WRITE;
    in_ch.address = '0;
    in_ch.write_data = '0;
    in_ch.timer_request = 0;
    in_ch.terminal_request = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed table; step rows carry their instruction in data
    rows = '{
      '{HOP_REG,   32'd15,        '0,            0, 0, 1, PC_RESET,      ERR_NONE},
      '{HOP_REG,   32'd18,        '0,            0, 0, 1, '0,            ERR_NONE},
      '{HOP_REG,   32'hFFFF_FFFF, '0,            0, 0, 1, '0,            ERR_NONE},
      '{HOP_READ,  32'h0000_1000, '0,            0, 0, 1, '0,            ERR_NONE},
      '{HOP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, '0,            ERR_NONE},
      '{HOP_READ,  32'hFFFF_FFFF, '0,            0, 0, 1, 32'hFFFF_FFFF, ERR_NONE},
      '{HOP_STEP,  '0, encode(4'hF, 0, 0, 0, 0, 0),               0, 0, 1, '0, ERR_UNK_OP},
      '{HOP_STEP,  '0, encode(OP_ARITH, 4'hF, 1, 2, 3, 0),        0, 0, 1, '0, ERR_MODE},
      '{HOP_STEP,  '0, encode(OP_ARITH, MD_DIV, 1, 2, 3, 0),      0, 0, 1, '0, ERR_DIV0},
      '{HOP_STEP,  '0, encode(OP_LOAD, MD_LD_IMM, 1, 0, 0, 12'hF00), 0, 0, 0, '0, ERR_NONE},
      '{HOP_STEP,  '0, encode(OP_LOAD, MD_LD_IMM, 2, 0, 0, 12'h7FF), 0, 0, 0, '0, ERR_NONE},
      '{HOP_STEP,  '0, encode(OP_STORE, MD_ST_DIR, 1, 0, 2, 0),   0, 0, 0, '0, ERR_NONE},
      '{HOP_STEP,  '0, encode(OP_LOAD, MD_LD_IMM, 3, 0, 0, 12'h800), 0, 0, 0, '0, ERR_NONE},
      '{HOP_STEP,  '0, encode(OP_LOGIC, MD_NOT, 4, 0, 0, 0),      0, 0, 0, '0, ERR_NONE},
      '{HOP_STEP,  '0, encode(OP_ARITH, MD_DIV, 5, 3, 4, 0),      1, 1, 0, '0, ERR_NONE},
      '{HOP_STEP,  '0, encode(OP_LOAD, MD_LD_MEM, 6, 14, 0, 12'hFF8), 1, 0, 0, '0, ERR_NONE},
      '{HOP_STEP,  '0, encode(OP_SHIFT, MD_SHR, 7, 4, 2, 0),      0, 1, 0, '0, ERR_NONE},
      '{HOP_STEP,  '0, encode(OP_INT, 0, 0, 0, 0, 0),             0, 0, 0, '0, ERR_NONE},
      '{HOP_STEP,  '0, encode(OP_SHIFT, MD_SHL, 8, 4, 2, 0),      0, 0, 0, '0, ERR_NONE},
      '{HOP_STEP,  '0, encode(OP_CALL, MD_CALL_DIR, 0, 0, 0, 12'h100), 0, 0, 0, '0, ERR_NONE},
      '{HOP_REG,   32'd16,        '0,            0, 0, 0, '0,            ERR_NONE},
      '{HOP_REG,   32'd14,        '0,            0, 0, 0, '0,            ERR_NONE}
    };
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.op == HOP_STEP) step_with(rw.data, rw.tmr, rw.trm, rw.typed, rw.exp_err);
      else send(rw.op, rw.addr, rw.data, rw.tmr, rw.trm, rw.typed, rw.exp_rd, rw.exp_err);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 70) hold_req = 1;
      if (n == 110) quiet = 1;
      if (n == 150) quiet = 0;
      if (n == 190) wait_drained();
      pick = $urandom_range(99);
      if (pick < 70) begin
        step_with(random_insn(), $urandom_range(7) == 0, $urandom_range(7) == 0);
      end else if (pick < 80) begin
        send(HOP_REG, $urandom_range(3) == 0 ? $urandom : $urandom_range(20), $urandom, $urandom,
             $urandom);
      end else if (pick < 90) begin
        send(HOP_READ, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send(HOP_WRITE, $urandom, $urandom, $urandom, $urandom);
      end
    end

    // halt, then a step that must be ignored, then host access still works
    step_with(encode(OP_HALT, 0, 0, 0, 0, 0), 0, 0);
    send(HOP_STEP, '0, '0, 1, 1);
    send(HOP_REG, 32'd15, '0, 0, 0);
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS teaching_cpu_instruction_step");
    end else begin
      $display("FAIL teaching_cpu_instruction_step");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/tcis_pkg.sv
src/tcis_if.sv
src/teaching_cpu_instruction_step.sv
src/tcis_checker.sv
tb/tb_top.sv
